// File: hdl/lph_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; imported by linear_probe_hash_table, lph_checker and tb.
package lph_pkg;

    // Field widths of one request and one result
    localparam int KEY_W = 31;
    localparam int PAY_W = 32;
    localparam int CNT_W = 32;

    // Hash input is 2*key+1, reduced HASH_STEP bits per cycle
    localparam int HASH_W    = KEY_W + 1;
    localparam int HASH_STEP = 4;
    localparam int HASH_CYC  = HASH_W / HASH_STEP;
    localparam int HCNT_W    = $clog2(HASH_CYC);

    // Request op codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Slot marks
    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_FULL    = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

    // One slot of the table memory
    typedef struct packed {
        t_mark              mark;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
    } t_slot;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

// File: hdl/linear_probe_hash_table.sv
// Open-addressed hash table with linear probing and tombstones.
// Depends on lph_pkg for slot layout, codes and sequencer states.
//
// Each request (insert, search or delete) is hashed to slot (2*key+1) mod TABLE_DEPTH by a
// shared compare-subtract reducer that takes HASH_STEP bits a cycle, then probes one slot per
// cycle through the single slot memory, whose read data is registered. A request holds the
// block busy from accept to the next accept while it probes P slots (1 up to TABLE_DEPTH);
// an unused op code skips the hash and probe steps. After reset the block clears every slot
// mark to empty, one slot a cycle, and accepts no request until the clearing pass is done.
// A finished result waits in an output register, so the next request can be taken while it
// is still unread.
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_op,
    input  logic [lph_pkg::KEY_W-1:0] i_key,
    input  logic [lph_pkg::PAY_W-1:0] i_payload,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [lph_pkg::PAY_W-1:0] o_found_payload,
    output logic [lph_pkg::CNT_W-1:0] o_collision_total
);
    import lph_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W:0]   DEPTH_V = (IDX_W+1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_V  = IDX_W'(TABLE_DEPTH - 1);

    // Control state
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [HCNT_W-1:0]   r_hcnt, n_hcnt;
    logic [CNT_W-1:0]    r_coll, n_coll;
    logic                r_out_valid, n_out_valid;

    // Request and result words
    logic [1:0]          r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [PAY_W-1:0]    r_pay, n_pay;
    logic [HASH_W-1:0]   r_hash_sh, n_hash_sh;
    logic [IDX_W-1:0]    r_rem, n_rem;
    logic [IDX_W-1:0]    r_probe, n_probe;
    logic [1:0]          r_status, n_status;
    logic [PAY_W-1:0]    r_found, n_found;
    logic [1:0]          r_out_status, n_out_status;
    logic [PAY_W-1:0]    r_out_found, n_out_found;
    logic [CNT_W-1:0]    r_out_coll, n_out_coll;

    // Slot memory and its registered read word
    t_slot               r_slot_mem [TABLE_DEPTH];
    t_slot               r_rd;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    t_slot               w_wdata;

    // Probe decisions
    logic                w_accept;
    logic                w_last_probe;
    logic                w_key_hit;
    logic                w_stop;
    logic [IDX_W-1:0]    w_next_idx;
    logic [IDX_W-1:0]    w_hash_rem;

    assign o_in_ready        = (r_state == S_IDLE);
    assign w_accept          = i_in_valid && o_in_ready;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_found_payload   = r_out_found;
    assign o_collision_total = r_out_coll;

    // Reduce HASH_STEP bits of the hash word into the running remainder
    always_comb begin
        logic [IDX_W:0]   t;
        logic [IDX_W-1:0] rem;
        rem = r_rem;
        for (int b = 0; b < HASH_STEP; b++) begin
            t = {rem, r_hash_sh[HASH_W-1-b]};
            if (t >= DEPTH_V) begin
                t = t - DEPTH_V;
            end
            rem = t[IDX_W-1:0];
        end
        w_hash_rem = rem;
    end

    // Probe step decisions
    assign w_last_probe = (r_probe == LAST_V);
    assign w_next_idx   = (r_idx == LAST_V) ? '0 : r_idx + 1'b1;
    assign w_key_hit    = (r_rd.mark == MARK_FULL) && (r_rd.key == r_key);
    always_comb begin
        if (r_op == OP_INSERT) begin
            w_stop = (r_rd.mark != MARK_FULL) || w_last_probe;
        end else begin
            w_stop = (r_rd.mark == MARK_EMPTY) || w_key_hit || w_last_probe;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_V) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_INSERT || i_op == OP_SEARCH || i_op == OP_DELETE) begin
                        n_state = S_HASH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_HASH: begin
                if (r_hcnt == HCNT_W'(HASH_CYC - 1)) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_stop) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result updates
    always_comb begin
        n_idx        = r_idx;
        n_hcnt       = r_hcnt;
        n_coll       = r_coll;
        n_op         = r_op;
        n_key        = r_key;
        n_pay        = r_pay;
        n_hash_sh    = r_hash_sh;
        n_rem        = r_rem;
        n_probe      = r_probe;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_coll   = r_out_coll;
        unique case (r_state)
            S_CLEAR: begin
                n_idx = w_next_idx;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op      = i_op;
                    n_key     = i_key;
                    n_pay     = i_payload;
                    n_hash_sh = {i_key, 1'b1};
                    n_rem     = '0;
                    n_hcnt    = '0;
                    n_probe   = '0;
                    n_status  = ST_MISS;
                    n_found   = '0;
                end
            end
            S_HASH: begin
                n_rem     = w_hash_rem;
                n_hash_sh = r_hash_sh << HASH_STEP;
                n_hcnt    = r_hcnt + 1'b1;
                // first probe address; the memory read starts at this edge
                if (r_hcnt == HCNT_W'(HASH_CYC - 1)) n_idx = w_hash_rem;
            end
            S_CHECK: begin
                if (r_op == OP_INSERT) begin
                    if (r_rd.mark != MARK_FULL) begin
                        n_status = ST_OK;
                    end else begin
                        n_coll = r_coll + 1'b1;
                        if (w_last_probe) n_status = ST_FULL;
                    end
                end else begin
                    if (w_key_hit) begin
                        n_status = ST_OK;
                        if (r_op == OP_SEARCH) n_found = r_rd.payload;
                    end
                end
                // advance to the neighbor slot and read it
                if (!w_stop) begin
                    n_idx   = w_next_idx;
                    n_probe = r_probe + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_coll   = r_coll;
                end
            end
            default: ;
        endcase
    end

    // Slot memory write: clearing pass, insert fill, delete tombstone
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '{mark: MARK_EMPTY, key: '0, payload: '0};
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == S_CHECK) begin
            if (r_op == OP_INSERT && r_rd.mark != MARK_FULL) begin
                w_we    = 1'b1;
                w_wdata = '{mark: MARK_FULL, key: r_key, payload: r_pay};
            end else if (r_op == OP_DELETE && w_key_hit) begin
                w_we    = 1'b1;
                w_wdata = '{mark: MARK_DELETED, key: r_rd.key, payload: r_rd.payload};
            end
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_slot_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_slot_mem[n_idx];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_hcnt      <= '0;
            r_coll      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_hcnt      <= n_hcnt;
            r_coll      <= n_coll;
            r_out_valid <= n_out_valid;
        end
    end

    // Word registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_pay        <= n_pay;
        r_hash_sh    <= n_hash_sh;
        r_rem        <= n_rem;
        r_probe      <= n_probe;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_coll   <= n_out_coll;
    end

    // Memory writes happen only in the clearing pass or on a probe
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_CHECK))
        else $error("slot memory written outside clear or probe");

    // Collision count moves only while an insert probes
    a_coll_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_CHECK && r_op == OP_INSERT) |=> $stable(r_coll))
        else $error("collision count changed outside an insert probe");

    // A taken request keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("block ready right after accepting a word");

    // Probe counter never passes the table depth
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_probe <= LAST_V))
        else $error("probe counter beyond table depth");

    // Payload is returned only on a successful lookup
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_found_payload == '0))
        else $error("payload returned with a failing status");

endmodule

// File: tb/sv/lph_checker.sv
`timescale 1ns / 1ps
// Checker for linear_probe_hash_table: keeps its own copy of the slot table, works out each
// result word and compares the block's results field by field. Depends on lph_pkg.
module lph_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [1:0]                i_op,
    input  logic [lph_pkg::KEY_W-1:0] i_key,
    input  logic [lph_pkg::PAY_W-1:0] i_payload,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [1:0]                i_status,
    input  logic [lph_pkg::PAY_W-1:0] i_found_payload,
    input  logic [lph_pkg::CNT_W-1:0] i_collision_total,
    output int unsigned               o_result_count,
    output int unsigned               o_fail_count
);
    import lph_pkg::*;

    // One expected result word
    typedef struct packed {
        logic [1:0]       status;
        logic [PAY_W-1:0] found;
        logic [CNT_W-1:0] total;
    } t_answer;

    logic [KEY_W-1:0] slot_keys  [DEPTH];
    logic [PAY_W-1:0] slot_pays  [DEPTH];
    t_mark            slot_marks [DEPTH];
    logic [CNT_W-1:0] collisions;
    t_answer          answers_due [$];
    int unsigned      results_taken = 0;
    int unsigned      fail_total = 0;

    assign o_result_count = results_taken;
    assign o_fail_count   = fail_total;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        $display("[%0t] result %0d: %s is %h, expected %h", $time, results_taken, what,
                 got, want);
        fail_total++;
    endtask

    // Apply one request to the mirrored table and return the result it yields
    function automatic t_answer probe_table(input logic [1:0] op,
                                            input logic [KEY_W-1:0] key,
                                            input logic [PAY_W-1:0] pay);
        t_answer         ans;
        longint unsigned hash;
        int unsigned     idx;
        ans.status = ST_MISS;
        ans.found  = '0;
        hash = 2 * {33'd0, key} + 1;
        idx  = int'(hash % DEPTH);
        case (op)
            OP_INSERT: begin
                ans.status = ST_FULL;
                for (int n = 0; n < DEPTH; n++) begin
                    if (slot_marks[idx] != MARK_FULL) begin
                        slot_keys[idx]  = key;
                        slot_pays[idx]  = pay;
                        slot_marks[idx] = MARK_FULL;
                        ans.status      = ST_OK;
                        break;
                    end
                    collisions = collisions + 1'b1;
                    idx = (idx + 1) % DEPTH;
                end
            end
            OP_SEARCH, OP_DELETE: begin
                for (int n = 0; n < DEPTH; n++) begin
                    if (slot_marks[idx] == MARK_EMPTY) break;
                    if (slot_marks[idx] == MARK_FULL && slot_keys[idx] == key) begin
                        ans.status = ST_OK;
                        if (op == OP_SEARCH) ans.found = slot_pays[idx];
                        else slot_marks[idx] = MARK_DELETED;
                        break;
                    end
                    idx = (idx + 1) % DEPTH;
                end
            end
            default: ;
        endcase
        ans.total = collisions;
        return ans;
    endfunction

    // Watch both channels: compare the leaving word, then log the arriving one
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (slot_marks[i]) slot_marks[i] = MARK_EMPTY;
            collisions = '0;
            answers_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unrequested result, total", i_collision_total, '0);
                end else begin
                    want = answers_due.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", CNT_W'(i_status), CNT_W'(want.status));
                    if (i_found_payload !== want.found)
                        report_mismatch("found_payload", i_found_payload, want.found);
                    if (i_collision_total !== want.total)
                        report_mismatch("collision_total", i_collision_total, want.total);
                end
                results_taken++;
            end
            if (i_in_valid && i_in_ready)
                answers_due.push_back(probe_table(i_op, i_key, i_payload));
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for linear_probe_hash_table: clock, reset, request stimulus,
// result backpressure, watchdog and verdict. Depends on lph_pkg, the block and lph_checker.
module tb;
    import lph_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int RANDOM_WORDS = 700;
    localparam int TAIL_WORDS   = 40;
    localparam int POOL_SIZE    = 48;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 12;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       req_op = OP_INSERT;
    logic [KEY_W-1:0] req_key = '0;
    logic [PAY_W-1:0] req_payload = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       res_status;
    logic [PAY_W-1:0] res_found;
    logic [CNT_W-1:0] res_total;

    int unsigned      words_sent = 0;
    int unsigned      results_taken;
    int unsigned      fail_count;
    int unsigned      stall_cycles = 0;
    bit               calm = 1'b0;     // no idling on either side
    bit               squeeze = 1'b0;  // ask the receiver for its long hold-off
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    linear_probe_hash_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_op              (req_op),
        .i_key             (req_key),
        .i_payload         (req_payload),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (res_status),
        .o_found_payload   (res_found),
        .o_collision_total (res_total)
    );

    lph_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_op              (req_op),
        .i_key             (req_key),
        .i_payload         (req_payload),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_status          (res_status),
        .i_found_payload   (res_found),
        .i_collision_total (res_total),
        .o_result_count    (results_taken),
        .o_fail_count      (fail_count)
    );

    // Offer one request word, with random idle cycles ahead of it, and hold until taken
    task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] key,
                             input logic [PAY_W-1:0] pay);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_op      <= op;
        req_key     <= key;
        req_payload <= pay;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // Drop valid and hold until every outstanding result word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        wait (results_taken == words_sent);
    endtask

    // Weighted op choice; the remainder goes to the unused code
    function automatic logic [1:0] pick_op(input int unsigned w_ins, input int unsigned w_srch,
                                           input int unsigned w_del);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < w_ins) return OP_INSERT;
        if (roll < w_ins + w_srch) return OP_SEARCH;
        if (roll < w_ins + w_srch + w_del) return OP_DELETE;
        return OP_UNUSED;
    endfunction

    // Key from the clustered pool with a chance of pool_pct percent, otherwise any key
    function automatic logic [KEY_W-1:0] pick_key(input int unsigned pool_pct);
        if ($urandom_range(99) < pool_pct) return key_pool[$urandom_range(POOL_SIZE - 1)];
        return KEY_W'($urandom);
    endfunction

    // Result ready: random stalls, calm stretches, one long hold-off when asked
    initial begin : result_sink
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge clk);
            if (squeeze && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // End the run when no word moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        // Pool keys land in the low slots so probe chains grow long
        foreach (key_pool[i])
            key_pool[i] = (KEY_W'($urandom) & 31'h7FFF_FE00) | KEY_W'($urandom_range(15));
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, collisions, tombstones, duplicates, wrap, unused op
        send_word(OP_SEARCH, 31'd5, 32'hFFFF_FFFF);
        send_word(OP_DELETE, 31'd5, 32'h0);
        send_word(OP_INSERT, 31'd0, 32'h0);
        send_word(OP_INSERT, 31'd512, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 31'h7FFF_FFFF, 32'hA5A5_A5A5);
        send_word(OP_INSERT, 31'h7FFF_FE00, 32'h5A5A_5A5A);
        send_word(OP_SEARCH, 31'd512, 32'h0);
        send_word(OP_SEARCH, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_DELETE, 31'd0, 32'h0);
        send_word(OP_SEARCH, 31'd0, 32'h0);
        send_word(OP_SEARCH, 31'h7FFF_FE00, 32'h0);
        send_word(OP_INSERT, 31'd1024, 32'h1234_5678);
        send_word(OP_INSERT, 31'd512, 32'h0F0F_0F0F);
        send_word(OP_SEARCH, 31'd512, 32'h0);
        send_word(OP_DELETE, 31'd512, 32'h0);
        send_word(OP_SEARCH, 31'd512, 32'h0);
        send_word(OP_DELETE, 31'd0, 32'hFFFF_FFFF);
        send_word(OP_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_UNUSED, 31'd0, 32'h0);
        send_word(OP_INSERT, 31'd511, 32'hC3C3_C3C3);
        send_word(OP_SEARCH, 31'd511, 32'h0);
        send_word(OP_DELETE, 31'h7FFF_FFFF, 32'h0);
        send_word(OP_SEARCH, 31'd511, 32'h0);
        drain_results();

        // Random mix on clustered keys; calm stretch, then one long receiver hold-off
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= 100 && i < 300);
            if (i == 450) squeeze = 1'b1;
            send_word(pick_op(40, 35, 20), pick_key(75), $urandom);
        end
        drain_results();

        // Fill every remaining slot, then work the full table
        for (int i = 0; i < DEPTH; i++)
            send_word(OP_INSERT, pick_key(10), $urandom);
        for (int i = 0; i < TAIL_WORDS; i++)
            send_word(pick_op(30, 35, 25), pick_key(60), $urandom);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: linear_probe_hash_table.f
hdl/lph_pkg.sv
hdl/linear_probe_hash_table.sv
tb/sv/lph_checker.sv
tb/sv/tb.sv
